// ===== hw/rtl/rtc_bcd_datetime_decoder_defines.svh =====
// assertion macros for the rtc date/time decoder
`ifndef RTC_BCD_DATETIME_DECODER_DEFINES_SVH
`define RTC_BCD_DATETIME_DECODER_DEFINES_SVH

// implication checked at every clock edge outside reset
`define RTCD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rtc decoder check failed");

// condition that must never hold outside reset
`define RTCD_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("rtc decoder forbidden condition");

`endif

// ===== hw/rtl/rtcd_pkg.sv =====
// shared types, constants and month table for the rtc date/time decoder
package rtcd_pkg;

  // field masks of the raw clock registers
  localparam logic [7:0] SEC_MASK  = 8'h7F;
  localparam logic [7:0] MIN_MASK  = 8'h7F;
  localparam logic [7:0] HOUR_MASK = 8'h3F;
  localparam logic [7:0] DAY_MASK  = 8'h3F;
  localparam logic [7:0] MON_MASK  = 8'h1F;
  localparam logic [7:0] YEAR_MASK = 8'hFF;

  // upper limits of the decoded fields
  localparam logic [7:0] SEC_MAX  = 8'd59;
  localparam logic [7:0] MIN_MAX  = 8'd59;
  localparam logic [7:0] HOUR_MAX = 8'd23;
  localparam logic [7:0] DAY_MAX  = 8'd31;
  localparam logic [7:0] MON_MAX  = 8'd12;
  localparam logic [7:0] YEAR_MAX = 8'd99;
  localparam logic [2:0] WDAY_MAX = 3'd6;

  localparam logic [3:0]  DIGIT_MAX  = 4'd9;
  localparam logic [4:0]  LEAP_FEB   = 5'd29;
  localparam logic [11:0] YEAR_BASE  = 12'd2000;
  localparam int          NUM_MONTHS = 12;
  localparam logic [3:0]  FEB        = 4'd2;

  localparam logic [4:0] MONTH_DAYS [NUM_MONTHS] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // stage 1 word: bcd fields converted, digit checks done
  typedef struct packed {
    logic [7:0] sec_v;
    logic [7:0] min_v;
    logic [7:0] hour_v;
    logic [7:0] day_v;
    logic [7:0] mon_v;
    logic [7:0] year_v;
    logic [2:0] wday;
    logic       digits_ok;
    logic       clk_ok;
  } s1_t;

  // stage 2 word: range checks done, month length known
  typedef struct packed {
    logic       ok;
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [4:0] day;
    logic [2:0] wday;
    logic [3:0] mon;
    logic [6:0] yy;
    logic [4:0] mlen;
    logic       clk_ok;
  } s2_t;

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [3:0] idx;
    logic [4:0] len;
    idx = mon - 4'd1;
    if (mon == 4'd0 || mon > 4'(NUM_MONTHS)) begin
      len = MONTH_DAYS[0];
    end else if (mon == FEB && leap) begin
      len = LEAP_FEB;
    end else begin
      len = MONTH_DAYS[idx];
    end
    return len;
  endfunction

endpackage

// ===== hw/rtl/rtcd_bcd_field.sv =====
// two-digit bcd to binary converter with low-digit check
module rtcd_bcd_field import rtcd_pkg::*; (
  input  logic [7:0] bcd,
  output logic [7:0] value,
  output logic       digit_ok
);

  logic [3:0] hi;
  logic [3:0] lo;

  assign hi = bcd[7:4];
  assign lo = bcd[3:0];

  // hi * 10 as hi * 8 + hi * 2
  assign value    = {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {4'b0000, lo};
  assign digit_ok = (lo <= DIGIT_MAX);

endmodule

// ===== hw/rtl/rtc_bcd_datetime_decoder.sv =====
// Decodes one snapshot of the seven raw rtc date/time registers into binary
// fields with a pass/fail status. Three register stages: bcd conversion,
// range checks with month-length lookup, then the day-of-month check, year
// offset and zeroing of failed words. A word can enter every cycle while
// in_stall is low; out_stall only holds the pipeline, with empty stages
// still filling up.
// The block keeps no state between words.
`include "rtc_bcd_datetime_decoder_defines.svh"

module rtc_bcd_datetime_decoder import rtcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  seconds_reg,
  input  logic [7:0]  minutes_reg,
  input  logic [7:0]  hours_reg,
  input  logic [7:0]  days_reg,
  input  logic [7:0]  weekdays_reg,
  input  logic [7:0]  months_reg,
  input  logic [7:0]  years_reg,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [5:0]  second,
  output logic [5:0]  minute,
  output logic [4:0]  hour,
  output logic [4:0]  day,
  output logic [2:0]  weekday,
  output logic [3:0]  month,
  output logic [11:0] year,
  output logic        clock_valid
);

  logic v1, v2, v3;
  logic en1, en2, en3;
  s1_t  s1, s1_next;
  s2_t  s2, s2_next;

  // a stage loads when empty or when its word moves on
  assign en3      = !v3 || !out_stall;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // stage 1: bcd conversion
  logic [7:0] sec_v, min_v, hour_v, day_v, mon_v, year_v;
  logic       sec_d, min_d, hour_d, day_d, mon_d, year_d;

  rtcd_bcd_field u_sec  (.bcd(seconds_reg & SEC_MASK),  .value(sec_v),  .digit_ok(sec_d));
  rtcd_bcd_field u_min  (.bcd(minutes_reg & MIN_MASK),  .value(min_v),  .digit_ok(min_d));
  rtcd_bcd_field u_hour (.bcd(hours_reg & HOUR_MASK),   .value(hour_v), .digit_ok(hour_d));
  rtcd_bcd_field u_day  (.bcd(days_reg & DAY_MASK),     .value(day_v),  .digit_ok(day_d));
  rtcd_bcd_field u_mon  (.bcd(months_reg & MON_MASK),   .value(mon_v),  .digit_ok(mon_d));
  rtcd_bcd_field u_year (.bcd(years_reg & YEAR_MASK),   .value(year_v), .digit_ok(year_d));

  always_comb begin
    s1_next.sec_v     = sec_v;
    s1_next.min_v     = min_v;
    s1_next.hour_v    = hour_v;
    s1_next.day_v     = day_v;
    s1_next.mon_v     = mon_v;
    s1_next.year_v    = year_v;
    s1_next.wday      = weekdays_reg[2:0];
    s1_next.digits_ok = sec_d && min_d && hour_d && day_d && mon_d && year_d;
    s1_next.clk_ok    = !seconds_reg[7];
  end

  always_ff @(posedge clk) begin
    if (en1) s1 <= s1_next;
  end

  // stage 2: limit checks and month length
  always_comb begin
    s2_next.ok = s1.digits_ok && (s1.sec_v <= SEC_MAX) && (s1.min_v <= MIN_MAX) &&
                 (s1.hour_v <= HOUR_MAX) && (s1.day_v <= DAY_MAX) &&
                 (s1.wday <= WDAY_MAX) && (s1.mon_v <= MON_MAX) &&
                 (s1.year_v <= YEAR_MAX);
    s2_next.sec    = s1.sec_v[5:0];
    s2_next.min    = s1.min_v[5:0];
    s2_next.hour   = s1.hour_v[4:0];
    s2_next.day    = s1.day_v[4:0];
    s2_next.wday   = s1.wday;
    s2_next.mon    = s1.mon_v[3:0];
    s2_next.yy     = s1.year_v[6:0];
    // base year is a multiple of four, so leap follows the two-digit year
    s2_next.mlen   = month_len(s1.mon_v[3:0], s1.year_v[1:0] == 2'b00);
    s2_next.clk_ok = s1.clk_ok;
  end

  always_ff @(posedge clk) begin
    if (en2) s2 <= s2_next;
  end

  // stage 3: date check, year offset, zero on failure
  logic good;
  assign good = s2.ok && (s2.mon != 4'd0) && (s2.day != 5'd0) && (s2.day <= s2.mlen);

  always_ff @(posedge clk) begin
    if (en3) begin
      status      <= !good;
      second      <= good ? s2.sec  : 6'd0;
      minute      <= good ? s2.min  : 6'd0;
      hour        <= good ? s2.hour : 5'd0;
      day         <= good ? s2.day  : 5'd0;
      weekday     <= good ? s2.wday : 3'd0;
      month       <= good ? s2.mon  : 4'd0;
      year        <= good ? (YEAR_BASE + {5'd0, s2.yy}) : 12'd0;
      clock_valid <= s2.clk_ok;
    end
  end

  logic fields_zero;
  logic date_legal;

  assign fields_zero = ({second, minute, hour, day, weekday, month, year} == '0);
  assign date_legal  = (month != 4'd0) && (month <= 4'd12) && (day != 5'd0) &&
                       (year >= YEAR_BASE) && (weekday <= WDAY_MAX);

  `RTCD_ASSERT_IMP(a_fail_zero, out_valid && status, fields_zero)
  `RTCD_ASSERT_IMP(a_pass_date, out_valid && !status, date_legal)
  `RTCD_ASSERT_IMP(a_stall_full, in_stall, v1 && v2 && v3 && out_stall)

endmodule
